// File: rtl/core/rsna_pkg.sv
// Package for the RDS station name assembler: shared constants and types.
// Used by every module of the block; depends on nothing.
package rsna_pkg;

  localparam int Segments     = 4;
  localparam int CharWidth    = 8;
  localparam int NameChars    = 2 * Segments;
  localparam int NameWidth    = NameChars * CharWidth;
  localparam int SegIdxWidth  = $clog2(Segments);
  localparam int BlockWidth   = 16;
  localparam int TimeoutWidth = 20;
  localparam int TimerWidth   = 20;

  localparam logic [TimeoutWidth-1:0] TimeoutReset = TimeoutWidth'(15000);
  localparam logic [BlockWidth-1:0]   BlockBLimit  = BlockWidth'(500);

  typedef enum logic {
    ActTick = 1'b0,
    ActPoll = 1'b1
  } action_e;

  typedef struct packed {
    action_e               action;
    logic                  rds_ready;
    logic [BlockWidth-1:0] block_b;
    logic [BlockWidth-1:0] block_d;
  } item_t;

  typedef struct packed {
    logic                 emit;
    logic [NameWidth-1:0] station_name;
    logic                 complete;
    logic                 changed;
  } result_t;

endpackage

// File: rtl/core/rsna_in_stage.sv
// Input register of the RDS station name assembler.
// Holds one accepted request until the collector takes it; uses rsna_pkg.
module rsna_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rsna_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output rsna_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  rsna_pkg::item_t item_q;
  logic            load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/core/rsna_name_cmp.sv
// String comparison of two station names, each read as a zero-terminated string.
// Pure logic over eight characters; uses rsna_pkg.
module rsna_name_cmp (
  input  logic [rsna_pkg::NameWidth-1:0] prev_i,
  input  logic [rsna_pkg::NameWidth-1:0] name_i,
  output logic                           differ_o
);

  localparam int Chars = rsna_pkg::NameChars;
  localparam int CharW = rsna_pkg::CharWidth;

  logic [Chars-1:0] eq;
  logic [Chars-1:0] nz;
  logic [Chars:0]   live;
  logic [Chars-1:0] hit;

  always_comb begin
    live[0] = 1'b1;
    for (int i = 0; i < Chars; i++) begin
      eq[i]     = prev_i[i*CharW +: CharW] == name_i[i*CharW +: CharW];
      nz[i]     = prev_i[i*CharW +: CharW] != '0;
      hit[i]    = live[i] && !eq[i];
      live[i+1] = live[i] && eq[i] && nz[i];
    end
  end

  assign differ_o = |hit;

endmodule

// File: rtl/core/rsna_collector.sv
// Collection state, timer and timeout register of the RDS station name assembler.
// Works one request per cycle while valid_i is high; uses rsna_pkg and rsna_name_cmp.
module rsna_collector #(
  parameter int TIMER_WIDTH = rsna_pkg::TimerWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [rsna_pkg::TimeoutWidth-1:0] cfg_data_i,
  input  logic                              valid_i,
  input  rsna_pkg::item_t                   item_i,
  output rsna_pkg::result_t                 result_o
);

  localparam int NameW = rsna_pkg::NameWidth;
  localparam int Segs  = rsna_pkg::Segments;
  localparam int SegW  = 2 * rsna_pkg::CharWidth;
  localparam int CmpW  = (TIMER_WIDTH > rsna_pkg::TimeoutWidth) ?
                         TIMER_WIDTH : rsna_pkg::TimeoutWidth;

  logic [rsna_pkg::TimeoutWidth-1:0] timeout_q;
  logic [Segs-1:0]                   done_q, done_d;
  logic [NameW-1:0]                  name_q, name_d;
  logic [TIMER_WIDTH-1:0]            elapsed_q, elapsed_d;
  logic [NameW-1:0]                  prev_q, prev_d;

  logic [TIMER_WIDTH-1:0]            elapsed_inc;
  logic [rsna_pkg::SegIdxWidth-1:0]  seg;
  logic                              fill;
  logic                              timed_out;
  logic [Segs-1:0]                   done_fill;
  logic [NameW-1:0]                  name_fill;
  logic [NameW-1:0]                  out_name;
  logic                              emit;
  logic                              complete;
  logic                              differ;

  assign elapsed_inc = elapsed_q + TIMER_WIDTH'(1);
  assign timed_out   = (CmpW'(elapsed_inc) >= CmpW'(timeout_q)) || (&elapsed_inc);
  assign seg         = item_i.block_b[rsna_pkg::SegIdxWidth-1:0];
  assign fill        = item_i.rds_ready && (item_i.block_b < rsna_pkg::BlockBLimit) &&
                       !done_q[seg];

  always_comb begin
    done_fill = done_q;
    name_fill = name_q;
    for (int s = 0; s < Segs; s++) begin
      if (seg == rsna_pkg::SegIdxWidth'(s)) begin
        done_fill[s] = 1'b1;
        name_fill[s*SegW +: SegW] = {item_i.block_d[7:0], item_i.block_d[15:8]};
      end
    end
  end

  always_comb begin
    done_d    = done_q;
    name_d    = name_q;
    elapsed_d = elapsed_q;
    prev_d    = prev_q;
    emit      = 1'b0;
    complete  = 1'b0;
    out_name  = name_fill;
    if (valid_i) begin
      unique case (item_i.action)
        rsna_pkg::ActTick: begin
          elapsed_d = elapsed_inc;
          out_name  = {name_q[NameW-1:rsna_pkg::CharWidth], {rsna_pkg::CharWidth{1'b0}}};
          emit      = timed_out;
        end
        rsna_pkg::ActPoll: begin
          if (fill) begin
            done_d   = done_fill;
            name_d   = name_fill;
            emit     = &done_fill;
            complete = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (emit) begin
        done_d    = '0;
        name_d    = '0;
        elapsed_d = '0;
        prev_d    = out_name;
      end
    end
  end

  rsna_name_cmp u_cmp (
    .prev_i   (prev_q),
    .name_i   (out_name),
    .differ_o (differ)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= rsna_pkg::TimeoutReset;
      done_q    <= '0;
      name_q    <= '0;
      elapsed_q <= '0;
      prev_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
      done_q    <= done_d;
      name_q    <= name_d;
      elapsed_q <= elapsed_d;
      prev_q    <= prev_d;
    end
  end

  assign result_o.emit         = emit;
  assign result_o.station_name = out_name;
  assign result_o.complete     = complete;
  assign result_o.changed      = differ;

endmodule

// File: rtl/core/rsna_out_stage.sv
// Result register of the RDS station name assembler.
// Holds one result until the receiver takes it; uses rsna_pkg.
module rsna_out_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rsna_pkg::result_t              result_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rsna_pkg::NameWidth-1:0] station_name_o,
  output logic                           complete_o,
  output logic                           changed_o
);

  logic                           valid_q, valid_d;
  logic [rsna_pkg::NameWidth-1:0] name_q;
  logic                           complete_q;
  logic                           changed_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
    if (result_i.emit) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.emit) begin
      name_q     <= result_i.station_name;
      complete_q <= result_i.complete;
      changed_q  <= result_i.changed;
    end
  end

  assign out_valid_o    = valid_q;
  assign station_name_o = name_q;
  assign complete_o     = complete_q;
  assign changed_o      = changed_q;

endmodule

// File: rtl/core/rds_station_name_assembler_core.sv
// RDS station name assembler, top level.
// Input requests are millisecond ticks or RDS polls on the in_ channel (valid and
// stall); results leave on the out_ channel (valid and stall). A poll with the
// ready flag set and block B below 500 fills the name segment given by block B
// bits 1:0 once; when all four segments are filled the eight-character name is
// sent with complete set. Ticks advance a timer; when it reaches the timeout value
// the partial name is sent with character 0 cleared and complete low. The
// changed flag compares the name with the previous result as a string.
// The timeout register is written over the cfg_ channel, which is always ready.
// A request is registered, worked on by the collection logic once it may advance,
// and its result, if any, is registered in the result register. One request is
// taken every cycle unless a result is held under out_stall_i; the figure is set
// by the single collection stage. While a result waits under out_stall_i, the
// input register holds its request and in_stall_o rises once that register is
// full. Reset empties both registers, clears the name buffer, marks, timer and
// the previous name, and sets the timeout to 15000 ticks.
module rds_station_name_assembler_core #(
  parameter int TIMER_WIDTH = rsna_pkg::TimerWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic                              rds_ready_i,
  input  logic [rsna_pkg::BlockWidth-1:0]   block_b_i,
  input  logic [rsna_pkg::BlockWidth-1:0]   block_d_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rsna_pkg::NameWidth-1:0]    station_name_o,
  output logic                              complete_o,
  output logic                              changed_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rsna_pkg::TimeoutWidth-1:0] cfg_data_i
);

  rsna_pkg::item_t   in_item;
  rsna_pkg::item_t   s1_item;
  rsna_pkg::result_t result;
  logic              s1_valid;
  logic              advance;

  assign in_item.action    = rsna_pkg::action_e'(action_i);
  assign in_item.rds_ready = rds_ready_i;
  assign in_item.block_b   = block_b_i;
  assign in_item.block_d   = block_d_i;

  assign advance     = s1_valid && (!out_valid_o || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  rsna_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  rsna_collector #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .valid_i     (advance),
    .item_i      (s1_item),
    .result_o    (result)
  );

  rsna_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_i       (result),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .station_name_o (station_name_o),
    .complete_o     (complete_o),
    .changed_o      (changed_o)
  );

`ifndef SYNTH
  a_stall_only_on_full_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register could move");

  a_emit_needs_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.emit |-> (!out_valid_o || !out_stall_i))
    else $error("result produced while the result register was held");

  a_timeout_clears_char0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !complete_o) |-> (station_name_o[7:0] == 8'h00))
    else $error("timed-out name with a nonzero first character");
`endif

endmodule
